FILE: rtl/zem_pkg.sv
// Package for the Z-algorithm exact match block: word types, command codes,
// register indexes and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package zem_pkg;

  localparam int CMD_W  = 2;
  localparam int SYM_W  = 8;
  localparam int IDX_W  = 12;
  localparam int Z_W    = 13;
  localparam int MPOS_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ_Z  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_MT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic [IDX_W-1:0] index;
  } in_item_t;

  typedef struct packed {
    logic [Z_W-1:0]    z_value;
    logic [MPOS_W-1:0] match_position;
    logic [Z_W-1:0]    match_count;
    logic              overflow;
    logic              status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic do_load;
    logic rd_issue;
    logic scan_init;
    logic q_from_k;
    logic zk_issue;
    logic z_from_zk;
    logic q_from_br;
    logic cmp_issue;
    logic q_inc;
    logic z_end;
    logic rec;
    logic out_load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             last;
    logic             k_ge_len;
    logic             k_ge_br;
    logic             zk_lt_beta;
    logic             q_lt_len;
    logic             sym_eq;
    logic             out_free;
  } dp_stat_t;

endpackage

FILE: rtl/z_array_exact_match.sv
// Top level of the Z-algorithm exact match block: controller plus datapath.
// Depends on zem_pkg, zem_ctrl, zem_dp (and zem_ram through zem_dp).
//
//   Channel   Direction  Handshake              Word
//   in        input      in_valid_i/in_ready_o   zem_pkg::in_item_t
//   out       output     out_valid_o/out_ready_i zem_pkg::out_item_t
//   cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One word is processed at a time. A read or plain load is captured, executed,
// and its result is loaded into the result register once that is free; the
// next word is accepted after that. A load with last runs the scan over each
// position in turn, with a buffer read for each symbol compare.
// Reset is asynchronous; the stores are not cleared.
// A waiting result does not block acceptance of the next word.
`timescale 1ns / 1ps

module z_array_exact_match #(
  parameter int MAX_LEN     = 4096,
  parameter int MAX_MATCHES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  zem_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output zem_pkg::out_item_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [zem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [zem_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  zem_pkg::ctl_cmd_t ctl_cmd;
  zem_pkg::dp_stat_t dp_stat;

  assign cfg_ready_o = 1'b1;

  zem_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .stat_i(dp_stat), .cmd_o(ctl_cmd)
  );

  zem_dp #(.MAX_LEN(MAX_LEN), .MAX_MATCHES(MAX_MATCHES)) u_dp (
    .clk_i, .rst_ni, .in_item_i, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .cmd_i(ctl_cmd), .stat_o(dp_stat), .out_valid_o, .out_ready_i, .out_item_o
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("new word accepted while one is in progress");

  a_error_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status) |->
      (out_item_o.z_value == '0 && out_item_o.match_position == '0))
    else $error("error result carries nonzero data");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before it was taken");

endmodule

FILE: rtl/zem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module zem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/zem_ctrl.sv
// Controller state machine for the Z-algorithm exact match block.
// Depends on zem_pkg for the command and status structs.
`timescale 1ns / 1ps

module zem_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  zem_pkg::dp_stat_t stat_i,
  output zem_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_EXEC   = 11'b000_0000_0010,
    S_SINIT  = 11'b000_0000_0100,
    S_POS    = 11'b000_0000_1000,
    S_ZK     = 11'b000_0001_0000,
    S_CMPRD  = 11'b000_0010_0000,
    S_CMPCHK = 11'b000_0100_0000,
    S_ZEND   = 11'b000_1000_0000,
    S_REC    = 11'b001_0000_0000,
    S_RESP   = 11'b010_0000_0000,
    S_SPARE  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.command == zem_pkg::CMD_LOAD) begin
          cmd_o.do_load = 1'b1;
          state_d = stat_i.last ? S_SINIT : S_RESP;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d = S_RESP;
        end
      end
      S_SINIT: begin
        cmd_o.scan_init = 1'b1;
        state_d = S_POS;
      end
      S_POS: begin
        if (stat_i.k_ge_len) begin
          state_d = S_RESP;
        end else if (stat_i.k_ge_br) begin
          cmd_o.q_from_k = 1'b1;
          state_d = S_CMPRD;
        end else begin
          cmd_o.zk_issue = 1'b1;
          state_d = S_ZK;
        end
      end
      S_ZK: begin
        // Inside a Z-box: reuse the earlier value unless it reaches the box end.
        if (stat_i.zk_lt_beta) begin
          cmd_o.z_from_zk = 1'b1;
          state_d = S_REC;
        end else begin
          cmd_o.q_from_br = 1'b1;
          state_d = S_CMPRD;
        end
      end
      S_CMPRD: begin
        if (stat_i.q_lt_len) begin
          cmd_o.cmp_issue = 1'b1;
          state_d = S_CMPCHK;
        end else begin
          state_d = S_ZEND;
        end
      end
      S_CMPCHK: begin
        if (stat_i.sym_eq) begin
          cmd_o.q_inc = 1'b1;
          state_d = S_CMPRD;
        end else begin
          state_d = S_ZEND;
        end
      end
      S_ZEND: begin
        cmd_o.z_end = 1'b1;
        state_d = S_REC;
      end
      S_REC: begin
        cmd_o.rec = 1'b1;
        state_d = S_POS;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/zem_dp.sv
// Datapath for the Z-algorithm exact match block: registers, string buffer,
// Z store, match store and output register. Depends on zem_pkg and zem_ram.
`timescale 1ns / 1ps

module zem_dp #(
  parameter int MAX_LEN     = 4096,
  parameter int MAX_MATCHES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  zem_pkg::in_item_t              in_item_i,
  input  logic                           cfg_valid_i,
  input  logic [zem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [zem_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  zem_pkg::ctl_cmd_t              cmd_i,
  output zem_pkg::dp_stat_t              stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output zem_pkg::out_item_t             out_item_o
);

  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int PW  = (LW > zem_pkg::IDX_W) ? LW : zem_pkg::IDX_W;
  localparam int ML  = $clog2(MAX_MATCHES + 1);
  localparam int MW  = (ML > PW) ? ML : PW;
  localparam int AW  = $clog2(MAX_LEN);
  localparam int MAW = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
  localparam int ZW  = zem_pkg::Z_W;
  localparam int NW  = zem_pkg::IDX_W;
  localparam int SW  = zem_pkg::SYM_W;
  localparam int OW  = zem_pkg::MPOS_W;

  logic          text_mode_q;
  logic [NW-1:0] pat_len_q, start_q;
  zem_pkg::in_item_t item_q;
  logic [PW-1:0] len_q, len_d, len_eff;
  logic          scan_done_q, scan_done_d;
  logic [PW-1:0] zb_q, zb_d, ze_q, ze_d;
  logic [MW-1:0] mf_q, mf_d, stored;
  logic          ovf_q, ovf_d;
  logic [PW-1:0] k_q, k_d, q_q, q_d, bl_q, bl_d, br_q, br_d, z_q, z_d;
  logic          out_valid_q;
  zem_pkg::out_item_t out_q;

  logic [ZW-1:0] zram_rdata;
  logic [OW-1:0] mram_rdata;
  logic [SW-1:0] buf_a_rdata, buf_b_rdata;
  logic          buf_we, zram_we, zram_re, mram_we, hit_now, mf_room;
  logic          zvalid, mvalid, status;
  logic [PW-1:0] idx_p;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_mode_q <= 1'b0;
      pat_len_q   <= NW'(1);
      start_q     <= NW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        zem_pkg::CFG_TEXT_MODE:   text_mode_q <= cfg_data_i[0];
        zem_pkg::CFG_PATTERN_LEN: pat_len_q   <= cfg_data_i[NW-1:0];
        zem_pkg::CFG_START_INDEX: start_q     <= cfg_data_i[NW-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff  = scan_done_q ? '0 : len_q;
  assign buf_we   = cmd_i.do_load && (len_eff < PW'(MAX_LEN));
  assign hit_now  = text_mode_q && (z_q == PW'(pat_len_q));
  assign mf_room  = mf_q < MW'(MAX_MATCHES);
  assign zram_we  = cmd_i.rec && !text_mode_q;
  assign mram_we  = cmd_i.rec && hit_now && mf_room;
  assign zram_re  = cmd_i.zk_issue || cmd_i.rd_issue;

  always_comb begin
    len_d       = len_q;
    scan_done_d = scan_done_q;
    zb_d = zb_q;
    ze_d = ze_q;
    mf_d = mf_q;
    ovf_d = ovf_q;
    k_d  = k_q;
    q_d  = q_q;
    bl_d = bl_q;
    br_d = br_q;
    z_d  = z_q;
    if (cmd_i.do_load) begin
      len_d       = buf_we ? len_eff + PW'(1) : len_eff;
      scan_done_d = item_q.last;
    end
    if (cmd_i.scan_init) begin
      k_d  = PW'(start_q);
      bl_d = '0;
      br_d = '0;
      if (text_mode_q) begin
        mf_d  = '0;
        ovf_d = 1'b0;
      end else begin
        zb_d = PW'(start_q);
        ze_d = len_q;
      end
    end
    if (cmd_i.q_from_k)  q_d = k_q;
    if (cmd_i.q_from_br) q_d = br_q;
    if (cmd_i.q_inc)     q_d = q_q + PW'(1);
    if (cmd_i.z_from_zk) z_d = PW'(zram_rdata);
    if (cmd_i.z_end) begin
      z_d = q_q - k_q;
      if (q_q > k_q) begin
        bl_d = k_q;
        br_d = q_q;
      end
    end
    if (cmd_i.rec) begin
      k_d = k_q + PW'(1);
      if (hit_now) begin
        mf_d = mf_q + MW'(1);
        if (!mf_room) ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      scan_done_q <= 1'b0;
      zb_q        <= '0;
      ze_q        <= '0;
      mf_q        <= '0;
      ovf_q       <= 1'b0;
    end else begin
      len_q       <= len_d;
      scan_done_q <= scan_done_d;
      zb_q        <= zb_d;
      ze_q        <= ze_d;
      mf_q        <= mf_d;
      ovf_q       <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_item_i;
    k_q  <= k_d;
    q_q  <= q_d;
    bl_q <= bl_d;
    br_q <= br_d;
    z_q  <= z_d;
  end

  // Two copies of the buffer give both symbols of one compare in a cycle.
  zem_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_buf_a (
    .clk_i, .we_i(buf_we), .waddr_i(AW'(len_eff)), .wdata_i(item_q.symbol),
    .re_i(cmd_i.cmp_issue), .raddr_i(AW'(q_q)), .rdata_o(buf_a_rdata)
  );

  zem_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_buf_b (
    .clk_i, .we_i(buf_we), .waddr_i(AW'(len_eff)), .wdata_i(item_q.symbol),
    .re_i(cmd_i.cmp_issue), .raddr_i(AW'(q_q - k_q)), .rdata_o(buf_b_rdata)
  );

  zem_ram #(.WIDTH(ZW), .DEPTH(MAX_LEN)) u_zstore (
    .clk_i, .we_i(zram_we), .waddr_i(AW'(k_q)), .wdata_i(ZW'(z_q)),
    .re_i(zram_re),
    .raddr_i(cmd_i.zk_issue ? AW'(k_q - bl_q) : AW'(item_q.index)),
    .rdata_o(zram_rdata)
  );

  zem_ram #(.WIDTH(OW), .DEPTH(MAX_MATCHES)) u_mstore (
    .clk_i, .we_i(mram_we), .waddr_i(MAW'(mf_q)),
    .wdata_i(OW'(k_q - PW'(pat_len_q) - PW'(1))),
    .re_i(cmd_i.rd_issue), .raddr_i(MAW'(item_q.index)), .rdata_o(mram_rdata)
  );

  // Result word.
  assign idx_p  = PW'(item_q.index);
  assign zvalid = (idx_p >= zb_q) && (idx_p < ze_q) && (idx_p < PW'(MAX_LEN));
  assign stored = mf_room ? mf_q : MW'(MAX_MATCHES);
  assign mvalid = MW'(item_q.index) < stored;

  always_comb begin
    case (item_q.command)
      zem_pkg::CMD_LOAD:    status = 1'b0;
      zem_pkg::CMD_READ_Z:  status = !zvalid;
      zem_pkg::CMD_READ_MT: status = !mvalid;
      default:              status = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.z_value <= (item_q.command == zem_pkg::CMD_READ_Z && zvalid) ?
                       zram_rdata : '0;
      out_q.match_position <= (item_q.command == zem_pkg::CMD_READ_MT && mvalid) ?
                              mram_rdata : '0;
      out_q.match_count <= ZW'(mf_q);
      out_q.overflow    <= ovf_q;
      out_q.status      <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign stat_o.command    = item_q.command;
  assign stat_o.last       = item_q.last;
  assign stat_o.k_ge_len   = k_q >= len_q;
  assign stat_o.k_ge_br    = k_q >= br_q;
  assign stat_o.zk_lt_beta = PW'(zram_rdata) < (br_q - k_q);
  assign stat_o.q_lt_len   = q_q < len_q;
  assign stat_o.sym_eq     = buf_a_rdata == buf_b_rdata;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

FILE: bench/z_array_exact_match_tb.sv
// Self-checking testbench for z_array_exact_match: random and directed
// words, with a word-level predictor of the Z scan and match store.
// Depends on zem_pkg and the z_array_exact_match RTL.
`timescale 1ns / 1ps

module z_array_exact_match_tb;

  localparam int LEN_CAP   = 4096;
  localparam int MATCH_CAP = 1024;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int PREFILL_LEN = 64;
  localparam logic [zem_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  zem_pkg::in_item_t              in_item_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  zem_pkg::out_item_t             out_item_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [zem_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [zem_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  z_array_exact_match dut (.*);

  always #5 clk_i = ~clk_i;

  // Predicted block state.
  logic [7:0]  sym_buf  [LEN_CAP];
  logic [12:0] z_mem    [LEN_CAP];
  logic [11:0] hit_mem  [MATCH_CAP];
  int unsigned buf_len = 0, hits = 0, z_lo = 0, z_hi = 0;
  logic        hit_ovf = 1'b0, scanned = 1'b0;
  logic        mode_text = 1'b0;
  int unsigned pat_len = 1, scan_from = 1;

  zem_pkg::in_item_t  word_queue [$];
  zem_pkg::out_item_t expected_words [$];
  int        errors = 0;
  int        send_idle = 0, recv_idle = 0;
  logic      in_taken = 1'b0;
  logic      hold_req = 1'b0, hold_done = 1'b0;
  int        hold_left = 0;
  int        cycles = 0;

  task automatic z_scan();
    int unsigned bl, br, z, q, kp;
    bl = 0;
    br = 0;
    if (mode_text) begin
      hits = 0;
      hit_ovf = 1'b0;
    end else begin
      z_lo = scan_from;
      z_hi = buf_len;
    end
    for (int unsigned k = scan_from; k < buf_len; k++) begin
      if (k >= br) begin
        q = k;
        while (q < buf_len && sym_buf[q] == sym_buf[q-k]) q++;
        z = q - k;
        if (z > 0) begin
          bl = k;
          br = q;
        end
      end else begin
        kp = k - bl;
        if (z_mem[kp] < br - k) begin
          z = z_mem[kp];
        end else begin
          q = br;
          while (q < buf_len && sym_buf[q] == sym_buf[q-k]) q++;
          z = q - k;
          bl = k;
          br = q;
        end
      end
      if (mode_text) begin
        if (z == pat_len) begin
          if (hits < MATCH_CAP) hit_mem[hits] = 12'(k - pat_len - 1);
          else hit_ovf = 1'b1;
          hits++;
        end
      end else begin
        z_mem[k] = 13'(z);
      end
    end
  endtask

  task automatic predict_word(input zem_pkg::in_item_t w);
    zem_pkg::out_item_t r;
    int unsigned stored;
    r = '0;
    case (w.command)
      zem_pkg::CMD_LOAD: begin
        if (scanned) begin
          buf_len = 0;
          scanned = 1'b0;
        end
        if (buf_len < LEN_CAP) begin
          sym_buf[buf_len] = w.symbol;
          buf_len++;
        end
        if (w.last) begin
          z_scan();
          scanned = 1'b1;
        end
      end
      zem_pkg::CMD_READ_Z: begin
        if (w.index >= z_lo && w.index < z_hi) r.z_value = z_mem[w.index];
        else r.status = 1'b1;
      end
      zem_pkg::CMD_READ_MT: begin
        stored = (hits < MATCH_CAP) ? hits : MATCH_CAP;
        if (w.index < stored) r.match_position = hit_mem[w.index];
        else r.status = 1'b1;
      end
      default: r.status = 1'b1;
    endcase
    r.match_count = 13'(hits);
    r.overflow = hit_ovf;
    expected_words = {expected_words, r};
  endtask

  // Driver: a new word is offered only when none is pending on the port.
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) predict_word(in_item_i);
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (word_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_item_i  <= word_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off so that the block backs up.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        hold_left <= 400;
        hold_done <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    zem_pkg::out_item_t e;
    if (out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %p", $time, out_item_o);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_item_o.z_value !== e.z_value) begin
          $display("%0t: z_value expected %0d got %0d", $time, e.z_value,
                   out_item_o.z_value);
          errors++;
        end
        if (out_item_o.match_position !== e.match_position) begin
          $display("%0t: match_position expected %0d got %0d", $time,
                   e.match_position, out_item_o.match_position);
          errors++;
        end
        if (out_item_o.match_count !== e.match_count) begin
          $display("%0t: match_count expected %0d got %0d", $time,
                   e.match_count, out_item_o.match_count);
          errors++;
        end
        if (out_item_o.overflow !== e.overflow) begin
          $display("%0t: overflow expected %0b got %0b", $time, e.overflow,
                   out_item_o.overflow);
          errors++;
        end
        if (out_item_o.status !== e.status) begin
          $display("%0t: status expected %0b got %0b", $time, e.status,
                   out_item_o.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_word(input logic [1:0] cmd, input logic [7:0] sym,
                           input logic lst, input logic [11:0] idx);
    zem_pkg::in_item_t w;
    w.command = cmd;
    w.symbol = sym;
    w.last = lst;
    w.index = idx;
    word_queue = {word_queue, w};
  endtask

  task automatic push_string(input logic [7:0] str [$]);
    foreach (str[i]) push_word(zem_pkg::CMD_LOAD, str[i], i == str.size() - 1,
                               12'($urandom));
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (word_queue.size() > 0 || in_valid_i || expected_words.size() > 0);
  endtask

  task automatic write_reg(input logic [zem_pkg::CFG_IDX_W-1:0] idx,
                           input logic [zem_pkg::CFG_DATA_W-1:0] val);
    drain();
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o));
    case (idx)
      zem_pkg::CFG_TEXT_MODE:   mode_text = val[0];
      zem_pkg::CFG_PATTERN_LEN: pat_len = val;
      zem_pkg::CFG_START_INDEX: scan_from = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // A pattern run then a text run over pattern, separator and text with
  // planted occurrences, followed by reads and a little noise. The separator
  // differs from every pattern symbol, so Z-boxes never reach past it.
  task automatic run_batch();
    logic [7:0] pat [$];
    logic [7:0] str [$];
    logic [7:0] sym_a, sym_b, sep;
    int n, tlen;
    sym_a = 8'($urandom);
    sym_b = 8'($urandom);
    n = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
    for (int i = 0; i < n; i++) pat = {pat, ($urandom_range(1) ? sym_a : sym_b)};
    write_reg(zem_pkg::CFG_TEXT_MODE, 12'd0);
    write_reg(zem_pkg::CFG_PATTERN_LEN, 12'($urandom));
    case ($urandom_range(5))
      0: write_reg(zem_pkg::CFG_START_INDEX, 12'd0);
      1: write_reg(zem_pkg::CFG_START_INDEX, 12'($urandom_range(1, n + 2)));
      default: write_reg(zem_pkg::CFG_START_INDEX, 12'd1);
    endcase
    push_string(pat);
    for (int i = 0; i < 4; i++) push_word(zem_pkg::CMD_READ_Z, 8'($urandom),
                                          1'($urandom_range(1)),
                                          12'($urandom_range(n + 1)));
    push_word(zem_pkg::CMD_READ_Z, 8'($urandom), 1'($urandom_range(1)), 12'($urandom));
    write_reg(zem_pkg::CFG_TEXT_MODE, 12'd1);
    write_reg(zem_pkg::CFG_PATTERN_LEN, 12'(n));
    write_reg(zem_pkg::CFG_START_INDEX,
              ($urandom_range(3) == 0) ? 12'($urandom_range(1, n + 1)) : 12'd1);
    str = pat;
    do sep = 8'($urandom);
    while (sep == sym_a || sep == sym_b);
    str = {str, sep};
    tlen = $urandom_range(5, 40);
    while (str.size() < n + 1 + tlen) begin
      if ($urandom_range(2) == 0) str = {str, pat};
      else str = {str, ($urandom_range(1) ? sym_a : sym_b)};
    end
    push_string(str);
    for (int i = 0; i < 5; i++) push_word(zem_pkg::CMD_READ_MT, 8'($urandom),
                                          1'($urandom_range(1)),
                                          12'($urandom_range(tlen / 2 + 1)));
    push_word(zem_pkg::CMD_READ_Z, 8'($urandom), 1'($urandom_range(1)),
              12'($urandom_range(n + 1)));
    for (int i = 0; i < 3; i++) push_word(2'($urandom), 8'($urandom), 1'b0, 12'($urandom));
    push_word(zem_pkg::CMD_READ_MT, 8'($urandom), 1'b1, 12'($urandom));
    drain();
  endtask

  initial begin
    logic [7:0] str [$];
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle = 16;
    recv_idle = 54;
    // Reads before any scan, an unknown command, and an empty scan.
    push_word(zem_pkg::CMD_READ_Z, 8'h00, 1'b0, 12'd0);
    push_word(zem_pkg::CMD_READ_Z, 8'hff, 1'b1, 12'hfff);
    push_word(zem_pkg::CMD_READ_MT, 8'h00, 1'b0, 12'd0);
    push_word(CMD_UNUSED, 8'hff, 1'b1, 12'hfff);
    push_word(zem_pkg::CMD_LOAD, 8'h5a, 1'b1, 12'd0);
    push_word(zem_pkg::CMD_READ_Z, 8'h00, 1'b0, 12'd1);
    // A scan from position one fills the low Z entries that later scans
    // reuse, so no scan ever reads an entry that was never written.
    str = {};
    for (int i = 0; i < PREFILL_LEN; i++)
      str = {str, (($urandom_range(7) == 0) ? 8'hff : 8'h00)};
    push_string(str);
    push_word(zem_pkg::CMD_READ_Z, 8'h00, 1'b0, 12'hfff);
    push_word(zem_pkg::CMD_READ_Z, 8'h00, 1'b0, 12'd1);
    push_word(zem_pkg::CMD_READ_Z, 8'h00, 1'b0, 12'(PREFILL_LEN - 1));
    // A scan from position zero gives the full length there.
    write_reg(zem_pkg::CFG_START_INDEX, 12'd0);
    str = '{8'h61, 8'h62, 8'h61};
    push_string(str);
    push_word(zem_pkg::CMD_READ_Z, 8'h00, 1'b0, 12'd0);
    push_word(zem_pkg::CMD_READ_Z, 8'h00, 1'b0, 12'd2);
    write_reg(zem_pkg::CFG_START_INDEX, 12'd1);
    // Offset below zero wraps.
    write_reg(zem_pkg::CFG_TEXT_MODE, 12'd1);
    str = '{8'h61, 8'h61};
    push_string(str);
    push_word(zem_pkg::CMD_READ_MT, 8'h00, 1'b0, 12'd0);
    // More occurrences than the match store holds.
    str = '{8'h78, 8'h7c};
    for (int i = 0; i < MATCH_CAP + 80; i++) str = {str, 8'h78};
    push_string(str);
    push_word(zem_pkg::CMD_READ_MT, 8'h00, 1'b0, 12'd0);
    push_word(zem_pkg::CMD_READ_MT, 8'h00, 1'b0, 12'd1023);
    push_word(zem_pkg::CMD_READ_MT, 8'h00, 1'b0, 12'd1024);
    // Register extremes: nothing gets computed.
    write_reg(zem_pkg::CFG_PATTERN_LEN, 12'hfff);
    write_reg(zem_pkg::CFG_START_INDEX, 12'hfff);
    str = '{8'h01, 8'h02, 8'h03};
    push_string(str);
    push_word(zem_pkg::CMD_READ_MT, 8'h00, 1'b0, 12'd0);
    drain();

    for (int i = 0; i < 2; i++) run_batch();
    send_idle = 54;
    recv_idle = 16;
    for (int i = 0; i < 2; i++) run_batch();
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 2; i++) run_batch();

    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
